[hdl/afs_pkg.sv]
// Shared types, constants and helper functions for the affine transform stack.
`default_nettype none
package afs_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int ACC_W        = 66;
	localparam int DIV_W        = 2 * FRAC_BITS + 1;

	typedef logic signed [31:0] word_t;

	localparam word_t ONE_Q = 32'(1 << FRAC_BITS);
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [3:0] {
		FN_IDENT = 4'd0,
		FN_TRANS = 4'd1,
		FN_SCALE = 4'd2,
		FN_ROTX  = 4'd3,
		FN_ROTY  = 4'd4,
		FN_ROTZ  = 4'd5,
		FN_AXIS  = 4'd6,
		FN_SWAP  = 4'd7,
		FN_APPLY = 4'd8,
		FN_READ  = 4'd9
	} func_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ZERO_SCALE = 2'd1,
		ST_SAT        = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TRANS,
		S_DIV,
		S_TRIG,
		S_AXPROD,
		S_AXWAIT,
		S_AXADD,
		S_MUL,
		S_MWAIT,
		S_MCOPY,
		S_APPLY,
		S_AWAIT,
		S_READ,
		S_FIN
	} state_t;

	typedef struct packed {
		func_t              func;
		logic [15:0]        angle;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic               right_side;
		logic               is_dir;
		logic [2:0]         row_sel;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_w;
		status_t            status;
	} res_t;

	typedef struct packed {
		logic issue;
		logic first;
		logic last;
	} mac_ctl_t;

	typedef struct packed {
		logic  valid;
		logic  sat;
		word_t value;
	} mac_res_t;

	function automatic logic [32:0] sat_add(input word_t a, input word_t b, input logic sub);
		logic [32:0] s;
		s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
		if (s[32] != s[31]) begin
			return {1'b1, s[32] ? 32'h8000_0000 : 32'h7fff_ffff};
		end
		return {1'b0, s[31:0]};
	endfunction

	function automatic word_t ident_entry(input logic [3:0] idx);
		return (idx[1:0] == idx[3:2]) ? ONE_Q : '0;
	endfunction

	function automatic logic [29:0] cordic_atan(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:    v = 30'd536870912;
			5'd1:    v = 30'd316933406;
			5'd2:    v = 30'd167458907;
			5'd3:    v = 30'd85004756;
			5'd4:    v = 30'd42667331;
			5'd5:    v = 30'd21354465;
			5'd6:    v = 30'd10679838;
			5'd7:    v = 30'd5340245;
			5'd8:    v = 30'd2670163;
			5'd9:    v = 30'd1335087;
			5'd10:   v = 30'd667544;
			5'd11:   v = 30'd333772;
			5'd12:   v = 30'd166886;
			5'd13:   v = 30'd83443;
			5'd14:   v = 30'd41722;
			5'd15:   v = 30'd20861;
			5'd16:   v = 30'd10430;
			5'd17:   v = 30'd5215;
			5'd18:   v = 30'd2608;
			5'd19:   v = 30'd1304;
			5'd20:   v = 30'd652;
			5'd21:   v = 30'd326;
			5'd22:   v = 30'd163;
			5'd23:   v = 30'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

[hdl/afs_mac.sv]
// Shared multiply-accumulate unit with rounding and saturation of a dot product.
`default_nettype none
module afs_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  afs_pkg::mac_ctl_t ctl,
	input  afs_pkg::word_t    a,
	input  afs_pkg::word_t    b,
	output afs_pkg::mac_res_t res
);
	import afs_pkg::*;

	logic                    v_s1, first_s1, last_s1;
	logic signed [63:0]      prod_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic                    done_q;
	logic signed [ACC_W:0]   rnd, shf;
	logic                    in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			v_s1     <= ctl.issue;
			first_s1 <= ctl.first;
			last_s1  <= ctl.last;
			done_q   <= v_s1 & last_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		if (v_s1) begin
			acc_q <= (first_s1 ? '0 : acc_q) + ACC_W'(prod_s1);
		end
	end

	always_comb begin
		rnd      = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
		shf      = rnd >>> FRAC_BITS;
		in_range = (&shf[ACC_W:31]) | ~(|shf[ACC_W:31]);
	end

	assign res.valid = done_q;
	assign res.sat   = done_q & ~in_range;
	assign res.value = in_range ? shf[31:0] : (shf[ACC_W] ? 32'h8000_0000 : 32'h7fff_ffff);

endmodule
`default_nettype wire

[hdl/afs_cordic.sv]
// Iterative CORDIC that produces sine and cosine of a phase, one step per cycle.
`default_nettype none
module afs_cordic (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [15:0]    angle,
	output logic           done,
	output afs_pkg::word_t sin_v,
	output afs_pkg::word_t cos_v
);
	import afs_pkg::*;

	localparam int SH = 30 - FRAC_BITS;
	localparam logic signed [33:0] RND = 34'sd1 <<< (29 - FRAC_BITS);
	localparam logic signed [33:0] QTR = 34'sd1073741824;
	localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;

	logic               run_q, fin_q, done_q, flip_q;
	logic [4:0]         it_q;
	logic signed [33:0] x_q, y_q, z_q;
	word_t              sin_q, cos_q;
	logic [31:0]        phase;
	logic signed [33:0] z0, dx, dy, at, xf, yf, xr, yr;

	always_comb begin
		phase = {angle[ANGLE_BITS-1:0], {(32 - ANGLE_BITS){1'b0}}};
		z0    = 34'(signed'(phase));
		dx    = y_q >>> it_q;
		dy    = x_q >>> it_q;
		at    = 34'(cordic_atan(it_q));
		xf    = flip_q ? -x_q : x_q;
		yf    = flip_q ? -y_q : y_q;
		xr    = (xf + RND) >>> SH;
		yr    = (yf + RND) >>> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				it_q  <= '0;
			end else if (run_q) begin
				it_q <= it_q + 5'd1;
				if (it_q == 5'(CORDIC_STEPS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			if (z0 > QTR) begin
				z_q    <= z0 - HALF_TURN;
				flip_q <= 1'b1;
			end else if (z0 < -QTR) begin
				z_q    <= z0 + HALF_TURN;
				flip_q <= 1'b1;
			end else begin
				z_q    <= z0;
				flip_q <= 1'b0;
			end
		end else if (run_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
		if (fin_q) begin
			cos_q <= xr[31:0];
			sin_q <= yr[31:0];
		end
	end

	assign done  = done_q;
	assign sin_v = sin_q;
	assign cos_v = cos_q;

endmodule
`default_nettype wire

[hdl/afs_div.sv]
// Restoring divider that forms the rounded reciprocal of a scale factor.
`default_nettype none
module afs_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  afs_pkg::word_t divisor,
	output logic           done,
	output afs_pkg::word_t quot,
	output logic           sat
);
	import afs_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic              run_q, fin_q, done_q, neg_q, sat_q;
	logic [CW-1:0]     it_q;
	logic [31:0]       mag_q, mag;
	logic [DIV_W-1:0]  dvd_q, rem_q, quo_q, rem_sh;
	logic              ge;
	word_t             quot_q;

	always_comb begin
		mag    = divisor[31] ? 32'(-divisor) : divisor;
		rem_sh = {rem_q[DIV_W-2:0], dvd_q[DIV_W-1]};
		ge     = rem_sh >= DIV_W'(mag_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				it_q  <= '0;
			end else if (run_q) begin
				it_q <= it_q + 1'b1;
				if (it_q == CW'(DIV_W - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= divisor[31];
			mag_q <= mag;
			dvd_q <= (DIV_W'(1) << (2 * FRAC_BITS)) + DIV_W'(mag >> 1);
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? rem_sh - DIV_W'(mag_q) : rem_sh;
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
		if (fin_q) begin
			if (!neg_q && quo_q > DIV_W'(32'h7fff_ffff)) begin
				quot_q <= 32'h7fff_ffff;
				sat_q  <= 1'b1;
			end else if (neg_q && quo_q > DIV_W'(32'h8000_0000)) begin
				quot_q <= 32'h8000_0000;
				sat_q  <= 1'b1;
			end else begin
				quot_q <= neg_q ? 32'(-quo_q) : quo_q[31:0];
				sat_q  <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign sat  = sat_q;

endmodule
`default_nettype wire

[hdl/affine_transform_stack_top.sv]
// Top level: command sequencer, matrix registers and the shared arithmetic units.
// A command is taken when start is high while busy is low; busy then stays high until the
// result has been shown. Each command gives one result on res for exactly one cycle with done
// high, and the receiver cannot stall it. A translation, scale or rotation that updates the
// matrices uses the single shared multiplier, which does the 128 multiply-adds of the two 4x4
// matrix products one after another; rotations also wait for the CORDIC and scales for the
// divider, each of which runs one step per cycle.
`default_nettype none
module affine_transform_stack_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  afs_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output afs_pkg::res_t res
);
	import afs_pkg::*;

	state_t     state_q, state_d;
	cmd_t       cmd_q;
	logic [5:0] cnt_q;
	logic [4:0] rcnt_q;
	logic       pass_q, sat_q, zero_q;

	word_t fwd_q [16];
	word_t inv_q [16];
	word_t nm_q  [16];
	word_t ni_q  [16];
	word_t tmp_q [16];
	word_t prod_q[12];
	word_t out_q [4];
	word_t bn    [16];
	word_t bni   [16];

	logic [32:0] axs[9];
	logic [32:0] tng[3];

	mac_ctl_t mac_ctl;
	mac_res_t mac_r;
	word_t    mac_a, mac_b;

	logic  cor_start, cor_done, div_start, div_done, div_sat, load_n, bsat, accept;
	word_t cor_sin, cor_cos, div_q, tval, fwd_rd, inv_rd, nm_rd, ni_rd, vec_k;
	logic [3:0] ad_a, ad_b, fwd_ra, inv_ra, nm_ra, ni_ra;

	afs_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.res    (mac_r)
	);

	afs_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (cmd.angle),
		.done   (cor_done),
		.sin_v  (cor_sin),
		.cos_v  (cor_cos)
	);

	afs_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (cmd.vx),
		.done    (div_done),
		.quot    (div_q),
		.sat     (div_sat)
	);

	assign accept = start & (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mac_ctl   = '0;
		cor_start = 1'b0;
		div_start = 1'b0;
		load_n    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (cmd.func) inside
						FN_TRANS: state_d = S_TRANS;
						FN_SCALE: state_d = (cmd.vx == '0) ? S_FIN : S_DIV;
						FN_ROTX, FN_ROTY, FN_ROTZ: state_d = S_TRIG;
						FN_AXIS: state_d = (cmd.angle[ANGLE_BITS-1:0] == '0) ? S_FIN : S_TRIG;
						FN_APPLY: state_d = S_APPLY;
						FN_READ: state_d = S_READ;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_TRANS: begin
				load_n  = 1'b1;
				state_d = S_MUL;
			end
			S_DIV: begin
				if (div_done) begin
					load_n  = 1'b1;
					state_d = S_MUL;
				end
			end
			S_TRIG: begin
				if (cor_done) begin
					if (cmd_q.func == FN_AXIS) begin
						state_d = S_AXPROD;
					end else begin
						load_n  = 1'b1;
						state_d = S_MUL;
					end
				end
			end
			S_AXPROD: begin
				mac_ctl = '{issue: 1'b1, first: 1'b1, last: 1'b1};
				if (cnt_q == 6'd11) begin
					state_d = S_AXWAIT;
				end
			end
			S_AXWAIT: begin
				if (mac_r.valid && rcnt_q == 5'd11) begin
					state_d = S_AXADD;
				end
			end
			S_AXADD: begin
				load_n  = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				mac_ctl = '{issue: 1'b1, first: (cnt_q[1:0] == 2'd0), last: (cnt_q[1:0] == 2'd3)};
				if (cnt_q == 6'd63) begin
					state_d = S_MWAIT;
				end
			end
			S_MWAIT: begin
				if (mac_r.valid && rcnt_q == 5'd15) begin
					state_d = S_MCOPY;
				end
			end
			S_MCOPY: state_d = pass_q ? S_FIN : S_MUL;
			S_APPLY: begin
				mac_ctl = '{issue: 1'b1, first: (cnt_q[1:0] == 2'd0), last: (cnt_q[1:0] == 2'd3)};
				if (cnt_q == 6'd11) begin
					state_d = S_AWAIT;
				end
			end
			S_AWAIT: begin
				if (mac_r.valid && rcnt_q == 5'd2) begin
					state_d = S_FIN;
				end
			end
			S_READ: begin
				if (cnt_q == 6'd3) begin
					state_d = S_FIN;
				end
			end
			S_FIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_IDLE && start) begin
			cor_start = (cmd.func == FN_ROTX) || (cmd.func == FN_ROTY) || (cmd.func == FN_ROTZ) ||
				((cmd.func == FN_AXIS) && (cmd.angle[ANGLE_BITS-1:0] != '0));
			div_start = (cmd.func == FN_SCALE) && (cmd.vx != '0);
		end
	end

	always_comb begin
		ad_a   = {cnt_q[5:4], cnt_q[1:0]};
		ad_b   = {cnt_q[1:0], cnt_q[3:2]};
		nm_ra  = cmd_q.right_side ? ad_b : ad_a;
		ni_ra  = cmd_q.right_side ? ad_a : ad_b;
		fwd_ra = cmd_q.right_side ? ad_a : ad_b;
		inv_ra = cmd_q.right_side ? ad_b : ad_a;
		if (state_q == S_APPLY) begin
			fwd_ra = cnt_q[3:0];
		end else if (state_q == S_READ) begin
			fwd_ra = {cmd_q.row_sel[1:0], cnt_q[1:0]};
			inv_ra = {cmd_q.row_sel[1:0], cnt_q[1:0]};
		end
		fwd_rd = fwd_q[fwd_ra];
		inv_rd = inv_q[inv_ra];
		nm_rd  = nm_q[nm_ra];
		ni_rd  = ni_q[ni_ra];
		tval   = ONE_Q - cor_cos;
		case (cnt_q[1:0])
			2'd0:    vec_k = cmd_q.vx;
			2'd1:    vec_k = cmd_q.vy;
			2'd2:    vec_k = cmd_q.vz;
			default: vec_k = cmd_q.is_dir ? '0 : ONE_Q;
		endcase
	end

	always_comb begin
		mac_a = '0;
		mac_b = '0;
		case (state_q)
			S_AXPROD: begin
				case (cnt_q[3:0])
					4'd0:    begin mac_a = tval;      mac_b = cmd_q.vx; end
					4'd1:    begin mac_a = tval;      mac_b = cmd_q.vy; end
					4'd2:    begin mac_a = tval;      mac_b = cmd_q.vz; end
					4'd3:    begin mac_a = prod_q[0]; mac_b = cmd_q.vy; end
					4'd4:    begin mac_a = prod_q[0]; mac_b = cmd_q.vz; end
					4'd5:    begin mac_a = prod_q[1]; mac_b = cmd_q.vz; end
					4'd6:    begin mac_a = cor_sin;   mac_b = cmd_q.vx; end
					4'd7:    begin mac_a = cor_sin;   mac_b = cmd_q.vy; end
					4'd8:    begin mac_a = cor_sin;   mac_b = cmd_q.vz; end
					4'd9:    begin mac_a = prod_q[0]; mac_b = cmd_q.vx; end
					4'd10:   begin mac_a = prod_q[1]; mac_b = cmd_q.vy; end
					default: begin mac_a = prod_q[2]; mac_b = cmd_q.vz; end
				endcase
			end
			S_MUL: begin
				if (!pass_q) begin
					mac_a = cmd_q.right_side ? fwd_rd : nm_rd;
					mac_b = cmd_q.right_side ? nm_rd : fwd_rd;
				end else begin
					mac_a = cmd_q.right_side ? ni_rd : inv_rd;
					mac_b = cmd_q.right_side ? inv_rd : ni_rd;
				end
			end
			S_APPLY: begin
				mac_a = fwd_rd;
				mac_b = vec_k;
			end
			default: begin
				mac_a = '0;
				mac_b = '0;
			end
		endcase
	end

	// Entries of the axis rotation: products of the shared unit plus or minus cosine or sine terms.
	assign axs[0] = sat_add(prod_q[9],  cor_cos,   1'b0);
	assign axs[1] = sat_add(prod_q[3],  prod_q[8], 1'b1);
	assign axs[2] = sat_add(prod_q[4],  prod_q[7], 1'b0);
	assign axs[3] = sat_add(prod_q[3],  prod_q[8], 1'b0);
	assign axs[4] = sat_add(prod_q[10], cor_cos,   1'b0);
	assign axs[5] = sat_add(prod_q[5],  prod_q[6], 1'b1);
	assign axs[6] = sat_add(prod_q[4],  prod_q[7], 1'b1);
	assign axs[7] = sat_add(prod_q[5],  prod_q[6], 1'b0);
	assign axs[8] = sat_add(prod_q[11], cor_cos,   1'b0);
	assign tng[0] = sat_add('0, cmd_q.vx, 1'b1);
	assign tng[1] = sat_add('0, cmd_q.vy, 1'b1);
	assign tng[2] = sat_add('0, cmd_q.vz, 1'b1);

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			bn[i]  = ident_entry(4'(i));
			bni[i] = ident_entry(4'(i));
		end
		bsat = 1'b0;
		unique case (cmd_q.func) inside
			FN_TRANS: begin
				bn[3]   = cmd_q.vx;
				bn[7]   = cmd_q.vy;
				bn[11]  = cmd_q.vz;
				bni[3]  = tng[0][31:0];
				bni[7]  = tng[1][31:0];
				bni[11] = tng[2][31:0];
				bsat    = tng[0][32] | tng[1][32] | tng[2][32];
			end
			FN_SCALE: begin
				bn[0]   = cmd_q.vx;
				bn[5]   = cmd_q.vx;
				bn[10]  = cmd_q.vx;
				bni[0]  = div_q;
				bni[5]  = div_q;
				bni[10] = div_q;
				bsat    = div_sat;
			end
			FN_ROTX: begin
				bn[5]  = cor_cos;
				bn[10] = cor_cos;
				bn[6]  = -cor_sin;
				bn[9]  = cor_sin;
			end
			FN_ROTY: begin
				bn[0]  = cor_cos;
				bn[10] = cor_cos;
				bn[2]  = cor_sin;
				bn[8]  = -cor_sin;
			end
			FN_ROTZ: begin
				bn[0] = cor_cos;
				bn[5] = cor_cos;
				bn[1] = -cor_sin;
				bn[4] = cor_sin;
			end
			FN_AXIS: begin
				bn[0]  = axs[0][31:0];
				bn[1]  = axs[1][31:0];
				bn[2]  = axs[2][31:0];
				bn[4]  = axs[3][31:0];
				bn[5]  = axs[4][31:0];
				bn[6]  = axs[5][31:0];
				bn[8]  = axs[6][31:0];
				bn[9]  = axs[7][31:0];
				bn[10] = axs[8][31:0];
				bsat   = axs[0][32] | axs[1][32] | axs[2][32] | axs[3][32] | axs[4][32] |
					axs[5][32] | axs[6][32] | axs[7][32] | axs[8][32];
			end
			default: bsat = 1'b0;
		endcase
		if ((cmd_q.func == FN_ROTX) || (cmd_q.func == FN_ROTY) || (cmd_q.func == FN_ROTZ) ||
			(cmd_q.func == FN_AXIS)) begin
			for (int i = 0; i < 16; i++) begin
				bni[{i[1:0], i[3:2]}] = bn[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rcnt_q <= '0;
			pass_q <= 1'b0;
			sat_q  <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			if ((state_q == S_AXPROD) || (state_q == S_MUL) || (state_q == S_APPLY) ||
				(state_q == S_READ)) begin
				cnt_q <= cnt_q + 6'd1;
			end else begin
				cnt_q <= '0;
			end
			if (mac_r.valid) begin
				rcnt_q <= rcnt_q + 5'd1;
			end else if ((state_q != S_AXPROD) && (state_q != S_AXWAIT) && (state_q != S_MUL) &&
				(state_q != S_MWAIT) && (state_q != S_APPLY) && (state_q != S_AWAIT)) begin
				rcnt_q <= '0;
			end
			if (state_q == S_IDLE) begin
				pass_q <= 1'b0;
			end else if (state_q == S_MCOPY) begin
				pass_q <= 1'b1;
			end
			if (accept) begin
				sat_q  <= 1'b0;
				zero_q <= (cmd.func == FN_SCALE) && (cmd.vx == '0);
			end else begin
				sat_q <= sat_q | (mac_r.valid & mac_r.sat) | (load_n & bsat);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				fwd_q[i] <= ident_entry(4'(i));
				inv_q[i] <= ident_entry(4'(i));
			end
		end else begin
			if (accept && cmd.func == FN_IDENT) begin
				for (int i = 0; i < 16; i++) begin
					fwd_q[i] <= ident_entry(4'(i));
					inv_q[i] <= ident_entry(4'(i));
				end
			end else if (accept && cmd.func == FN_SWAP) begin
				for (int i = 0; i < 16; i++) begin
					fwd_q[i] <= inv_q[i];
					inv_q[i] <= fwd_q[i];
				end
			end else if (state_q == S_MCOPY) begin
				for (int i = 0; i < 16; i++) begin
					if (pass_q) begin
						inv_q[i] <= tmp_q[i];
					end else begin
						fwd_q[i] <= tmp_q[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			for (int i = 0; i < 4; i++) begin
				out_q[i] <= '0;
			end
		end
		if (load_n) begin
			for (int i = 0; i < 16; i++) begin
				nm_q[i] <= bn[i];
				ni_q[i] <= bni[i];
			end
		end
		if (mac_r.valid) begin
			case (state_q)
				S_AXPROD, S_AXWAIT: prod_q[rcnt_q[3:0]] <= mac_r.value;
				S_MUL, S_MWAIT:     tmp_q[rcnt_q[3:0]]  <= mac_r.value;
				S_APPLY, S_AWAIT:   out_q[rcnt_q[1:0]]  <= mac_r.value;
				default:            ;
			endcase
		end
		if (state_q == S_READ) begin
			out_q[cnt_q[1:0]] <= cmd_q.row_sel[2] ? inv_rd : fwd_rd;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = (state_q == S_FIN);
	assign res.out_x  = out_q[0];
	assign res.out_y  = out_q[1];
	assign res.out_z  = out_q[2];
	assign res.out_w  = out_q[3];
	assign res.status = zero_q ? ST_ZERO_SCALE : (sat_q ? ST_SAT : ST_OK);

	a_no_stray_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mac_r.valid)
		else $error("shared unit delivered a result while the sequencer was idle");

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("sequencer did not return to idle after a result");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.status != 2'd3))
		else $error("result carries an undefined status");

	a_cordic_once: assert property (@(posedge clk) disable iff (!arst_n)
		cor_start |=> (state_q == S_TRIG))
		else $error("CORDIC started outside a rotation transaction");

endmodule
`default_nettype wire

[dv/afs_checker.sv]
// Checker: watches the command and result channels, predicts each result and compares it.
module afs_checker import afs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  busy,
	input  cmd_t  cmd,
	input  logic  done,
	input  res_t  res,
	output int    errors,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef word_t mat_t [16];

	mat_t  fwd_m, inv_m;
	res_t  res_q [$];
	logic  sat_flag;

	function automatic word_t clamp(input longint v);
		if (v > 64'sd2147483647) begin
			sat_flag = 1'b1;
			return 32'sh7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			sat_flag = 1'b1;
			return 32'sh8000_0000;
		end
		return word_t'(v);
	endfunction

	function automatic word_t dot4(input word_t a [4], input word_t b [4], input int n);
		longint hi, lo, p, h;
		hi = 0;
		lo = 0;
		for (int k = 0; k < n; k++) begin
			p = longint'(a[k]) * longint'(b[k]);
			h = p >>> FRAC_BITS;
			hi += h;
			lo += p - (h <<< FRAC_BITS);
		end
		return clamp(hi + ((lo + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS));
	endfunction

	function automatic word_t qmul(input word_t a, input word_t b);
		word_t x [4], y [4];
		x = '{a, 0, 0, 0};
		y = '{b, 0, 0, 0};
		return dot4(x, y, 1);
	endfunction

	function automatic mat_t matmul(input mat_t a, input mat_t b);
		mat_t  r;
		word_t x [4], y [4];
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				for (int k = 0; k < 4; k++) begin
					x[k] = a[i * 4 + k];
					y[k] = b[k * 4 + j];
				end
				r[i * 4 + j] = dot4(x, y, 4);
			end
		end
		return r;
	endfunction

	function automatic mat_t identity();
		mat_t m;
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE_Q : '0;
		return m;
	endfunction

	function automatic mat_t transpose(input mat_t m);
		mat_t t;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) t[j * 4 + i] = m[i * 4 + j];
		return t;
	endfunction

	function automatic void sin_cos(input logic [15:0] ang, output word_t s, output word_t c);
		longint p, z, x, y, dx, dy, half;
		logic   flip;
		p = (longint'(ang & ((1 << ANGLE_BITS) - 1)) << (32 - ANGLE_BITS)) & 64'hffff_ffff;
		z = (p >= 64'h8000_0000) ? p - 64'h1_0000_0000 : p;
		x = 652032874;
		y = 0;
		flip = 1'b0;
		if (z > 64'sh4000_0000) begin
			z -= 64'sh8000_0000;
			flip = 1'b1;
		end else if (z < -64'sh4000_0000) begin
			z += 64'sh8000_0000;
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(cordic_atan(5'(i)));
			end else begin
				x += dx;
				y -= dy;
				z += longint'(cordic_atan(5'(i)));
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		half = 64'sd1 <<< (29 - FRAC_BITS);
		c = word_t'((x + half) >>> (30 - FRAC_BITS));
		s = word_t'((y + half) >>> (30 - FRAC_BITS));
	endfunction

	function automatic void compose(input mat_t n, input mat_t ni, input logic right);
		if (!right) begin
			fwd_m = matmul(n, fwd_m);
			inv_m = matmul(inv_m, ni);
		end else begin
			fwd_m = matmul(fwd_m, n);
			inv_m = matmul(ni, inv_m);
		end
	endfunction

	function automatic res_t predict_result(input cmd_t c);
		res_t    r;
		mat_t    n, ni, tmp;
		word_t   v [3], s, co, t, tx, ty, tz, txy, txz, tyz, sx, sy, sz;
		word_t   row [4], vec [4];
		longint  mag, q;
		int      a, b;
		r = '0;
		r.status = ST_OK;
		sat_flag = 1'b0;
		v = '{c.vx, c.vy, c.vz};
		case (c.func)
			FN_IDENT: begin
				fwd_m = identity();
				inv_m = identity();
			end
			FN_TRANS: begin
				n = identity();
				ni = identity();
				for (int i = 0; i < 3; i++) begin
					n[i * 4 + 3] = v[i];
					ni[i * 4 + 3] = clamp(-longint'(v[i]));
				end
				compose(n, ni, c.right_side);
			end
			FN_SCALE: begin
				if (v[0] == 0) begin
					r.status = ST_ZERO_SCALE;
				end else begin
					mag = (v[0] < 0) ? -longint'(v[0]) : longint'(v[0]);
					q = ((64'sd1 <<< (2 * FRAC_BITS)) + mag / 2) / mag;
					t = clamp((v[0] < 0) ? -q : q);
					n = identity();
					ni = identity();
					for (int i = 0; i < 3; i++) begin
						n[i * 5] = v[0];
						ni[i * 5] = t;
					end
					compose(n, ni, c.right_side);
				end
			end
			FN_ROTX, FN_ROTY, FN_ROTZ: begin
				a = (c.func == FN_ROTX) ? 1 : 0;
				b = (c.func == FN_ROTZ) ? 1 : 2;
				sin_cos(c.angle, s, co);
				n = identity();
				n[a * 5] = co;
				n[b * 5] = co;
				if (c.func == FN_ROTY) begin
					n[a * 4 + b] = s;
					n[b * 4 + a] = -s;
				end else begin
					n[a * 4 + b] = -s;
					n[b * 4 + a] = s;
				end
				compose(n, transpose(n), c.right_side);
			end
			FN_AXIS: begin
				if ((c.angle & ((1 << ANGLE_BITS) - 1)) != 0) begin
					sin_cos(c.angle, s, co);
					t = clamp(longint'(ONE_Q) - co);
					tx = qmul(t, v[0]);
					ty = qmul(t, v[1]);
					tz = qmul(t, v[2]);
					txy = qmul(tx, v[1]);
					txz = qmul(tx, v[2]);
					tyz = qmul(ty, v[2]);
					sx = qmul(s, v[0]);
					sy = qmul(s, v[1]);
					sz = qmul(s, v[2]);
					n = identity();
					n[0] = clamp(longint'(qmul(tx, v[0])) + co);
					n[1] = clamp(longint'(txy) - sz);
					n[2] = clamp(longint'(txz) + sy);
					n[4] = clamp(longint'(txy) + sz);
					n[5] = clamp(longint'(qmul(ty, v[1])) + co);
					n[6] = clamp(longint'(tyz) - sx);
					n[8] = clamp(longint'(txz) - sy);
					n[9] = clamp(longint'(tyz) + sx);
					n[10] = clamp(longint'(qmul(tz, v[2])) + co);
					compose(n, transpose(n), c.right_side);
				end
			end
			FN_SWAP: begin
				tmp = fwd_m;
				fwd_m = inv_m;
				inv_m = tmp;
			end
			FN_APPLY: begin
				vec = '{v[0], v[1], v[2], c.is_dir ? 32'sd0 : ONE_Q};
				for (int i = 0; i < 3; i++) begin
					for (int k = 0; k < 4; k++) row[k] = fwd_m[i * 4 + k];
					v[i] = dot4(row, vec, 4);
				end
				r.out_x = v[0];
				r.out_y = v[1];
				r.out_z = v[2];
			end
			FN_READ: begin
				tmp = (c.row_sel < 4) ? fwd_m : inv_m;
				r.out_x = tmp[c.row_sel[1:0] * 4 + 0];
				r.out_y = tmp[c.row_sel[1:0] * 4 + 1];
				r.out_z = tmp[c.row_sel[1:0] * 4 + 2];
				r.out_w = tmp[c.row_sel[1:0] * 4 + 3];
			end
			default: ;
		endcase
		if (r.status == ST_OK && sat_flag) r.status = ST_SAT;
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
			errors++;
		end
	endfunction

	assign pending = res_q.size();

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			fwd_m = identity();
			inv_m = identity();
			res_q.delete();
			errors = 0;
		end else begin
			if (done) begin
				if (res_q.size() == 0) begin
					$display("%0t: result with no transaction outstanding, actual %h",
						$realtime, res);
					errors++;
				end else begin
					want = res_q.pop_front();
					compare_field("out_x", want.out_x, res.out_x);
					compare_field("out_y", want.out_y, res.out_y);
					compare_field("out_z", want.out_z, res.out_z);
					compare_field("out_w", want.out_w, res.out_w);
					compare_field("status", 32'(want.status), 32'(res.status));
				end
			end
			if (start && !busy) res_q.push_back(predict_result(cmd));
		end
	end

endmodule

[dv/tb_affine_transform_stack_top.sv]
// Testbench top: drives commands into the transform stack and gives the verdict.
module tb_affine_transform_stack_top;
	import afs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;

	logic clk, arst_n, start, busy, done;
	cmd_t cmd;
	res_t res;
	int   errors, pending, stall_cycles;

	affine_transform_stack_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .done(done), .res(res)
	);

	afs_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .res(res), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic signed [31:0] rand_q();
		if ($urandom_range(0, 4) == 0) return $urandom;
		return int'($urandom_range(0, 524288)) - 262144;
	endfunction

	task automatic issue_cmd(input cmd_t c);
		int gap;
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
			: ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 3));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic cmd_t make_cmd(input func_t f, input logic [15:0] ang,
			input int x, input int y, input int z, input logic rs);
		cmd_t c;
		c.func = f;
		c.angle = ang;
		c.vx = x;
		c.vy = y;
		c.vz = z;
		c.right_side = rs;
		c.is_dir = 1'($urandom);
		c.row_sel = 3'($urandom);
		return c;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		int   sel;
		c = make_cmd(FN_IDENT, 16'($urandom), rand_q(), rand_q(), rand_q(), 1'($urandom));
		sel = $urandom_range(0, 99);
		if (sel < 4) c.func = FN_IDENT;
		else if (sel < 14) c.func = FN_TRANS;
		else if (sel < 22) begin
			c.func = FN_SCALE;
			case ($urandom_range(0, 5))
				0: c.vx = 0;
				1: c.vx = $urandom;
				default: c.vx = 65536 + int'($urandom_range(0, 32768)) - 16384;
			endcase
		end else if (sel < 37) c.func = func_t'($urandom_range(FN_ROTX, FN_ROTZ));
		else if (sel < 45) begin
			c.func = FN_AXIS;
			if ($urandom_range(0, 1) == 0) begin
				c.vx = 0;
				c.vy = 0;
				c.vz = 0;
				case ($urandom_range(0, 2))
					0: c.vx = $urandom_range(0, 1) ? 65536 : -65536;
					1: c.vy = $urandom_range(0, 1) ? 65536 : -65536;
					default: c.vz = $urandom_range(0, 1) ? 65536 : -65536;
				endcase
			end
			if ($urandom_range(0, 15) == 0) c.angle = 16'h0000;
		end else if (sel < 50) c.func = FN_SWAP;
		else if (sel < 72) c.func = FN_APPLY;
		else if (sel < 96) c.func = FN_READ;
		else c.func = func_t'($urandom_range(10, 15));
		return c;
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < 8; r++) issue_cmd(make_cmd(FN_READ, 0, 0, 0, 0, 0) | 3'(r));
		issue_cmd(make_cmd(FN_TRANS, 0, 32'h7fff_ffff, 32'h8000_0000, 65536, 0));
		issue_cmd(make_cmd(FN_APPLY, 0, 32'h7fff_ffff, 32'h8000_0000, -1, 0));
		issue_cmd(make_cmd(FN_IDENT, 16'hffff, 0, 0, 0, 1));
		issue_cmd(make_cmd(FN_SCALE, 0, 0, 1, 1, 0));
		issue_cmd(make_cmd(FN_SCALE, 0, 1, 0, 0, 1));
		issue_cmd(make_cmd(FN_SCALE, 0, 32'h8000_0000, 0, 0, 0));
		issue_cmd(make_cmd(FN_IDENT, 0, 0, 0, 0, 0));
		issue_cmd(make_cmd(FN_ROTX, 16'h4000, 0, 0, 0, 0));
		issue_cmd(make_cmd(FN_ROTY, 16'h8000, 0, 0, 0, 1));
		issue_cmd(make_cmd(FN_ROTZ, 16'hc001, 0, 0, 0, 0));
		issue_cmd(make_cmd(FN_AXIS, 16'h0000, 65536, 0, 0, 0));
		issue_cmd(make_cmd(FN_AXIS, 16'h2000, 0, 0, 65536, 1));
		issue_cmd(make_cmd(FN_AXIS, 16'hffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0));
		issue_cmd(make_cmd(FN_SWAP, 0, 0, 0, 0, 0));
		issue_cmd(make_cmd(func_t'(4'd15), 16'hffff, -1, -1, -1, 1));
		issue_cmd(make_cmd(FN_READ, 0, 0, 0, 0, 0) | 3'd7);
		for (int i = 0; i < 1000; i++) begin
			if (i == 500) begin
				start <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			issue_cmd(random_cmd());
		end
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
